// ===== rtl/core/rsst_pkg.sv =====
package rsst_pkg;

   // Defaults for the top-level parameters.
   localparam int DEPTH_DEFAULT      = 1024;
   localparam int VALUE_BITS_DEFAULT = 32;

   // Fixed field widths of the item interface.
   localparam int IDX_BITS    = 10;
   localparam int COUNT_BITS  = 11;
   localparam int INPUT_BITS  = 32;
   localparam int SPREAD_BITS = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(1024);

   // Action codes carried in the request tuser.
   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   // Result status codes.
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // One decoded request handed to the tree walker.
   typedef struct packed {
      logic                  query;
      logic                  err;
      logic [IDX_BITS-1:0]   first;
      logic [IDX_BITS-1:0]   last;
      logic [INPUT_BITS-1:0] value;
   } job_type;

   // One result handed back by the tree walker.
   typedef struct packed {
      logic [SPREAD_BITS-1:0] spread;
      logic                   status;
   } result_type;

endpackage

// ===== rtl/core/rsst_ram.sv =====
module rsst_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rsst_walker.sv =====
module rsst_walker
   import rsst_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   output logic       job_ready,
   input  job_type    job,
   output logic       res_valid,
   input  logic       res_ready,
   output result_type res
);

   localparam int NODE_COUNT = 2 * DEPTH;
   localparam int NODE_BITS  = $clog2(NODE_COUNT);
   localparam int PTR_BITS   = NODE_BITS + 1;
   localparam int WORD_BITS  = 2 * VALUE_BITS;

   localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic [NODE_BITS-1:0]  ROOT    = NODE_BITS'(1);
   localparam logic [NODE_BITS-1:0]  LAST_NODE = NODE_BITS'(NODE_COUNT - 1);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_UP    = 6'b000100,
      ST_QL    = 6'b001000,
      ST_QR    = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [NODE_BITS-1:0]  clr_ff, clr_in;
   logic [NODE_BITS-1:0]  cur_ff, cur_in;
   logic [PTR_BITS-1:0]   l_ff, l_in;
   logic [PTR_BITS-1:0]   r_ff, r_in;
   logic [VALUE_BITS-1:0] acc_max_ff, acc_max_in;
   logic [VALUE_BITS-1:0] acc_min_ff, acc_min_in;
   logic                  pend_ff, pend_in;
   logic                  err_ff, err_in;

   logic                  wr_en;
   logic [NODE_BITS-1:0]  wr_addr;
   logic [WORD_BITS-1:0]  wr_data;
   logic                  rd_en;
   logic [NODE_BITS-1:0]  rd_addr;
   logic [WORD_BITS-1:0]  rd_data;

   logic [VALUE_BITS-1:0] rd_max, rd_min;
   logic [VALUE_BITS-1:0] cmb_max, cmb_min;
   logic [VALUE_BITS-1:0] new_val;
   logic [NODE_BITS-1:0]  leaf;
   logic [NODE_BITS-1:0]  parent;
   logic [PTR_BITS-1:0]   r_dec;

   // Node storage: maximum in the upper half of a word, minimum in the lower.
   rsst_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(NODE_COUNT)
   ) u_nodes (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_max  = rd_data[WORD_BITS-1:VALUE_BITS];
   assign rd_min  = rd_data[VALUE_BITS-1:0];
   assign new_val = job.value[VALUE_BITS-1:0];
   assign leaf    = NODE_BITS'(DEPTH) + NODE_BITS'(job.first);
   assign parent  = cur_ff >> 1;
   assign r_dec   = r_ff - PTR_BITS'(1);

   // Fold the node read in the previous cycle into the running pair.
   always_comb begin
      cmb_max = acc_max_ff;
      cmb_min = acc_min_ff;
      if (pend_ff) begin
         if ($signed(rd_max) > $signed(acc_max_ff)) begin
            cmb_max = rd_max;
         end
         if ($signed(rd_min) < $signed(acc_min_ff)) begin
            cmb_min = rd_min;
         end
      end
   end

   // Sequencer: clearing pass, leaf-to-root refresh and range walk.
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      cur_in     = cur_ff;
      l_in       = l_ff;
      r_in       = r_ff;
      acc_max_in = acc_max_ff;
      acc_min_in = acc_min_ff;
      pend_in    = 1'b0;
      err_in     = err_ff;
      wr_en      = 1'b0;
      wr_addr    = clr_ff;
      wr_data    = {VAL_MIN, VAL_MAX};
      rd_en      = 1'b0;
      rd_addr    = l_ff[NODE_BITS-1:0];
      job_ready  = 1'b0;
      res_valid  = 1'b0;
      res.spread = '0;
      res.status = STATUS_ERR;
      case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + NODE_BITS'(1);
            if (clr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               if (!job.query) begin
                  if (!job.err) begin
                     // Store the leaf and fetch its sibling.
                     wr_en      = 1'b1;
                     wr_addr    = leaf;
                     wr_data    = {new_val, new_val};
                     rd_en      = 1'b1;
                     rd_addr    = {leaf[NODE_BITS-1:1], ~leaf[0]};
                     cur_in     = leaf;
                     acc_max_in = new_val;
                     acc_min_in = new_val;
                     state_in   = ST_UP;
                  end
               end else if (job.err) begin
                  err_in   = 1'b1;
                  state_in = ST_RESP;
               end else begin
                  err_in     = 1'b0;
                  l_in       = PTR_BITS'(DEPTH) + PTR_BITS'(job.first);
                  r_in       = PTR_BITS'(DEPTH) + PTR_BITS'(job.last) + PTR_BITS'(1);
                  acc_max_in = VAL_MIN;
                  acc_min_in = VAL_MAX;
                  state_in   = ST_QL;
               end
            end
         end
         ST_UP: begin
            // The sibling word is always pending here.
            wr_en   = 1'b1;
            wr_addr = parent;
            if ($signed(rd_max) > $signed(acc_max_ff)) begin
               acc_max_in = rd_max;
            end
            if ($signed(rd_min) < $signed(acc_min_ff)) begin
               acc_min_in = rd_min;
            end
            wr_data = {acc_max_in, acc_min_in};
            cur_in  = parent;
            if (parent == ROOT) begin
               state_in = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = {parent[NODE_BITS-1:1], ~parent[0]};
            end
         end
         ST_QL: begin
            acc_max_in = cmb_max;
            acc_min_in = cmb_min;
            if (l_ff < r_ff) begin
               if (l_ff[0]) begin
                  rd_en   = 1'b1;
                  rd_addr = l_ff[NODE_BITS-1:0];
                  pend_in = 1'b1;
                  l_in    = l_ff + PTR_BITS'(1);
               end
               state_in = ST_QR;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_QR: begin
            acc_max_in = cmb_max;
            acc_min_in = cmb_min;
            l_in       = l_ff >> 1;
            if (r_ff[0]) begin
               rd_en   = 1'b1;
               rd_addr = r_dec[NODE_BITS-1:0];
               pend_in = 1'b1;
               r_in    = r_dec >> 1;
            end else begin
               r_in = r_ff >> 1;
            end
            state_in = ST_QL;
         end
         ST_RESP: begin
            res_valid = 1'b1;
            if (!err_ff) begin
               res.spread = SPREAD_BITS'(signed'(acc_max_ff))
                          - SPREAD_BITS'(signed'(acc_min_ff));
               res.status = STATUS_OK;
            end
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state is reset; the walk registers are payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      l_ff       <= l_in;
      r_ff       <= r_in;
      acc_max_ff <= acc_max_in;
      acc_min_ff <= acc_min_in;
   end

`ifndef ASSERT_OFF
   // A range walk only reads the tree.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QL || state_ff == ST_QR) |-> !wr_en)
      else $error("tree written during a range walk");

   // Every refresh step consumes a sibling read issued in the previous cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UP) |-> $past(rd_en))
      else $error("refresh step without a pending sibling read");

   // A good result is only shown once every node read has been folded in.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && !err_ff) |-> !pend_ff)
      else $error("result shown with a node read still pending");
`endif

endmodule

// ===== rtl/core/range_spread_segment_tree_core.sv =====
// Range spread segment tree: keeps the maximum and minimum of DEPTH signed
// VALUE_BITS-bit elements in a segment tree held in one single-port-write,
// registered-read memory of 2*DEPTH words. A write item (tuser 0) stores one
// element and refreshes its path to the root at one tree level per cycle, and
// gives no result. A query item (tuser 1) walks the covering nodes bottom up
// and returns max minus min; an empty range or an index at or past the element
// count returns spread 0 with status 1. Each node visit costs one memory read.
// One item is worked on at a time; a new item is taken while a finished result
// still waits in the output register. After reset the block runs a clearing
// pass over every node before it takes its first item; the csr_wr_en write is
// taken at any time.
module range_spread_segment_tree_core
   import rsst_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [COUNT_BITS-1:0] csr_wr_data,  // element_count
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [55:0]           req_tdata,    // first_index, last_index, new_value, pad
   input  logic [0:0]            req_tuser,    // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata     // spread, status, pad
);

   localparam int CNT_BITS = (COUNT_BITS > $clog2(DEPTH + 1)) ? COUNT_BITS : $clog2(DEPTH + 1);

   logic [COUNT_BITS-1:0]  count_ff;
   logic [CNT_BITS-1:0]    count_ext;
   logic [CNT_BITS-1:0]    usable;
   logic [CNT_BITS-1:0]    first_ext;
   logic [CNT_BITS-1:0]    last_ext;
   logic [IDX_BITS-1:0]    first_idx;
   logic [IDX_BITS-1:0]    last_idx;
   logic                   is_query;
   job_type                job;
   logic                   job_ready;
   logic                   res_valid;
   logic                   res_ready;
   result_type             res;
   logic                   out_valid_ff;
   logic [SPREAD_BITS-1:0] out_spread_ff;
   logic                   out_status_ff;

   // Element count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // Decode the item and check its indices against the usable count.
   assign first_idx = req_tdata[IDX_BITS-1:0];
   assign last_idx  = req_tdata[2*IDX_BITS-1:IDX_BITS];
   assign is_query  = (req_tuser[0] == ACTION_QUERY);
   assign count_ext = CNT_BITS'(count_ff);
   assign usable    = (count_ext > CNT_BITS'(DEPTH)) ? CNT_BITS'(DEPTH) : count_ext;
   assign first_ext = CNT_BITS'(first_idx);
   assign last_ext  = CNT_BITS'(last_idx);

   always_comb begin
      job.query = is_query;
      job.first = first_idx;
      job.last  = last_idx;
      job.value = req_tdata[2*IDX_BITS+INPUT_BITS-1:2*IDX_BITS];
      if (is_query) begin
         job.err = (first_idx > last_idx) || (first_ext >= usable) || (last_ext >= usable);
      end else begin
         job.err = (first_ext >= usable);
      end
   end

   assign req_tready = job_ready;

   rsst_walker #(
      .DEPTH     (DEPTH),
      .VALUE_BITS(VALUE_BITS)
   ) u_walker (
      .clock    (clock),
      .reset    (reset),
      .job_valid(req_tvalid),
      .job_ready(job_ready),
      .job      (job),
      .res_valid(res_valid),
      .res_ready(res_ready),
      .res      (res)
   );

   // Output register decouples the walker from the result channel.
   assign res_ready = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         out_spread_ff <= res.spread;
         out_status_ff <= res.status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_status_ff, out_spread_ff};

endmodule
